### rtl/whe_pkg.sv
package whe_pkg;

    // command codes carried in s_tuser
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_MODE   = 3'd2;
    localparam logic [2:0] CMD_SPREAD = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [1:0] CFG_RANGE_MAX = 2'd1;
    localparam logic [1:0] CFG_BINS      = 2'd2;

    localparam int DIV_W   = 57;  // widest dividend: count * bins * 2^16
    localparam int IDX_W   = 9;   // bin count register width
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 40;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic             rem_nz;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN_DIV,
        ST_ADD_WR,
        ST_RPT_RD,
        ST_SWEEP,
        ST_LIK_DIV,
        ST_CTR_DIV,
        ST_SPR_HI,
        ST_SPR_LO,
        ST_DONE
    } state_t;

endpackage

### rtl/whe_bin_ram.sv
module whe_bin_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [whe_pkg::CNT_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [whe_pkg::CNT_W-1:0] rdata
);

    logic [whe_pkg::CNT_W-1:0] mem [DEPTH];
    logic [whe_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/whe_divider.sv
module whe_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [whe_pkg::DIV_W-1:0] num,
    input  logic [whe_pkg::DIV_W-1:0] den,
    output whe_pkg::div_res_t         res
);

    localparam int W  = whe_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    shifted;
    logic          ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        shifted   = {rem_reg[W-1:0], quot_reg[W-1]};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next  = ge ? shifted - {1'b0, den_reg} : shifted;
            quot_next = {quot_reg[W-2:0], ge};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign res.busy   = busy_reg;
    assign res.done   = done_reg;
    assign res.quot   = quot_reg;
    assign res.rem_nz = |rem_reg;

endmodule

### rtl/weighted_histogram_engine.sv
// weighted histogram over [range_min, range_max) split into bins_in_use equal bins; the bin
// weights live in a single-port-write, registered-read memory and every command is handled one
// request at a time, all arithmetic that needs a quotient going through one shared restoring
// divider of 57 iterations. an add whose sample misses the range and a read of a bin outside
// the bins in use skip the divider; find mode and likelihood spread sweep the memory one entry
// a cycle; a finished result waits in the done state until the output register is empty.
// after reset, and on a clear command, the store is zeroed by a pass over all MAX_BINS entries;
// during the pass after reset no request is taken (configuration writes still are).
// a finished result sits in the output register so the next request may be taken meanwhile.
module weighted_histogram_engine #(
    parameter int MAX_BINS = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // sample[15:0], weight[31:16], bin_select[39:32]
    input  logic [2:0]   s_tuser,   // cmd[2:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // bin_index[7:0], bin_value[39:8], total_weight[79:40],
                                    // likelihood_q16[111:80], bin_center_q16[143:112]
    output logic [0:0]   m_tuser    // in_range[0]
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int IW = whe_pkg::IDX_W;
    localparam int DW = whe_pkg::DIV_W;
    localparam int CW = whe_pkg::CNT_W;
    localparam int TW = whe_pkg::TOTAL_W;

    // configuration registers
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;
    logic [IW-1:0]      bins_reg;

    whe_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               clr_rpt_reg, clr_rpt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0]      total_reg, total_next;

    // working registers
    logic [2:0]         cmd_reg, cmd_next;
    logic [15:0]        weight_reg, weight_next;
    logic [IW-1:0]      sw_idx_reg, sw_idx_next;
    logic [IW-1:0]      mode_reg, mode_next;
    logic [CW-1:0]      hi_cnt_reg, hi_cnt_next;
    logic [CW-1:0]      lo_cnt_reg, lo_cnt_next;
    logic               ctr_neg_reg, ctr_neg_next;
    logic [IW-1:0]      res_idx_reg, res_idx_next;
    logic               res_in_reg, res_in_next;
    logic [CW-1:0]      res_val_reg, res_val_next;
    logic [31:0]        res_lik_reg, res_lik_next;
    logic [31:0]        res_ctr_reg, res_ctr_next;
    logic [143:0]       m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    // derived operating point
    logic [IW-1:0]      b_eff;
    logic signed [16:0] span;
    logic               rg_pos;
    logic signed [16:0] d_off;
    logic               in_rng;
    logic [24:0]        bin_num;
    logic [TW:0]        total_sum;

    // memory port
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [CW-1:0]      mem_rdata;

    // divider port
    logic               div_start;
    logic [DW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    whe_pkg::div_res_t  div_res;

    // likelihood and centre operands
    logic [CW-1:0]      lik_cnt;
    logic [40:0]        lik_cb;
    logic [55:0]        lik_den;
    logic [DW-1:0]      lik_num_op;
    logic [DW-1:0]      lik_den_op;
    logic [31:0]        div_lik;
    logic signed [27:0] ctr_prod;
    logic               ctr_neg;
    logic [26:0]        ctr_mag;
    logic [31:0]        ctr_val;
    logic [32:0]        add_sum;
    logic [CW-1:0]      add_sat;
    logic               sw_first;

    // inputs
    logic [2:0]         in_cmd;
    logic signed [15:0] in_sample;
    logic [15:0]        in_weight;
    logic [7:0]         in_sel;

    assign in_cmd    = s_tuser;
    assign in_sample = s_tdata[15:0];
    assign in_weight = s_tdata[31:16];
    assign in_sel    = s_tdata[39:32];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == whe_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // bin count clamped to 1 .. MAX_BINS
    always_comb begin
        if (bins_reg == '0) begin
            b_eff = IW'(1);
        end else if (32'(bins_reg) > MAX_BINS) begin
            b_eff = IW'(MAX_BINS);
        end else begin
            b_eff = bins_reg;
        end
    end

    assign span      = {max_reg[15], max_reg} - {min_reg[15], min_reg};
    assign rg_pos    = !span[16] && (span != '0);
    assign d_off     = {in_sample[15], in_sample} - {min_reg[15], min_reg};
    assign in_rng    = rg_pos && !d_off[16] && (d_off < span);
    assign bin_num   = 25'(d_off[15:0]) * 25'(b_eff);
    assign total_sum = {1'b0, total_reg} + (TW + 1)'(in_weight);

    // likelihood: count*bins*2^16 / (range*total), or 2^16/bins when degenerate
    assign lik_cb  = 41'(lik_cnt) * 41'(b_eff);
    assign lik_den = 56'(span[15:0]) * 56'(total_reg);
    always_comb begin
        if (!rg_pos || total_reg == '0) begin
            lik_num_op = DW'(65536);
            lik_den_op = DW'(b_eff);
        end else begin
            lik_num_op = {lik_cb, 16'b0};
            lik_den_op = DW'(lik_den);
        end
    end
    assign div_lik = (div_res.quot[DW-1:32] != '0) ? '1 : div_res.quot[31:0];

    // centre: floor((2n+1)*range*2^15 / bins) + min*2^16
    assign ctr_prod = 28'($signed({1'b0, res_idx_reg, 1'b1})) * 28'(span);
    assign ctr_neg  = ctr_prod[27];
    assign ctr_mag  = ctr_neg ? 27'(-ctr_prod) : ctr_prod[26:0];
    assign ctr_val  = (ctr_neg_reg ? -(div_res.quot[31:0] + 32'(div_res.rem_nz))
                                   : div_res.quot[31:0]) + {min_reg, 16'b0};

    assign add_sum  = {1'b0, mem_rdata} + 33'(weight_reg);
    assign add_sat  = add_sum[32] ? '1 : add_sum[31:0];
    assign sw_first = (sw_idx_reg == '0);

    // running extremes of the sweep, lowest index wins a tie
    always_comb begin
        hi_cnt_next = hi_cnt_reg;
        lo_cnt_next = lo_cnt_reg;
        mode_next   = mode_reg;
        if (state_reg == whe_pkg::ST_SWEEP) begin
            if (sw_first || mem_rdata > hi_cnt_reg) begin
                hi_cnt_next = mem_rdata;
                mode_next   = sw_idx_reg;
            end
            if (sw_first || mem_rdata < lo_cnt_reg) begin
                lo_cnt_next = mem_rdata;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_rpt_next  = clr_rpt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        total_next    = total_reg;
        cmd_next      = cmd_reg;
        weight_next   = weight_reg;
        sw_idx_next   = sw_idx_reg;
        ctr_neg_next  = ctr_neg_reg;
        res_idx_next  = res_idx_reg;
        res_in_next   = res_in_reg;
        res_val_next  = res_val_reg;
        res_lik_next  = res_lik_reg;
        res_ctr_next  = res_ctr_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_cnt_reg;
        mem_wdata     = '0;
        mem_raddr     = '0;
        div_start     = 1'b0;
        div_num       = lik_num_op;
        div_den       = lik_den_op;
        lik_cnt       = hi_cnt_next;

        unique case (state_reg)
            whe_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (clr_cnt_reg == AW'(MAX_BINS - 1)) begin
                    state_next = clr_rpt_reg ? whe_pkg::ST_DONE : whe_pkg::ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            whe_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    weight_next  = in_weight;
                    res_idx_next = '0;
                    res_in_next  = 1'b0;
                    res_val_next = '0;
                    res_lik_next = '0;
                    res_ctr_next = '0;
                    state_next   = whe_pkg::ST_DONE;
                    unique case (in_cmd) inside
                        whe_pkg::CMD_ADD: begin
                            total_next = total_sum[TW] ? '1 : total_sum[TW-1:0];
                            if (in_rng) begin
                                div_start  = 1'b1;
                                div_num    = DW'(bin_num);
                                div_den    = DW'(span[15:0]);
                                state_next = whe_pkg::ST_BIN_DIV;
                            end
                        end
                        whe_pkg::CMD_READ: begin
                            if ({1'b0, in_sel} < b_eff) begin
                                mem_raddr    = AW'(in_sel);
                                res_idx_next = IW'(in_sel);
                                state_next   = whe_pkg::ST_RPT_RD;
                            end
                        end
                        whe_pkg::CMD_MODE, whe_pkg::CMD_SPREAD: begin
                            sw_idx_next = '0;
                            state_next  = whe_pkg::ST_SWEEP;
                        end
                        whe_pkg::CMD_CLEAR: begin
                            total_next   = '0;
                            clr_cnt_next = '0;
                            clr_rpt_next = 1'b1;
                            state_next   = whe_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            whe_pkg::ST_BIN_DIV: begin
                if (div_res.done) begin
                    mem_raddr    = AW'(div_res.quot);
                    res_idx_next = IW'(div_res.quot);
                    state_next   = whe_pkg::ST_ADD_WR;
                end
            end
            whe_pkg::ST_ADD_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = AW'(res_idx_reg);
                mem_wdata    = add_sat;
                res_val_next = add_sat;
                res_in_next  = 1'b1;
                state_next   = whe_pkg::ST_DONE;
            end
            whe_pkg::ST_RPT_RD: begin
                lik_cnt      = mem_rdata;
                div_start    = 1'b1;
                res_val_next = mem_rdata;
                res_in_next  = 1'b1;
                state_next   = whe_pkg::ST_LIK_DIV;
            end
            whe_pkg::ST_SWEEP: begin
                if (sw_idx_reg == b_eff - IW'(1)) begin
                    div_start = 1'b1;
                    if (cmd_reg == whe_pkg::CMD_MODE) begin
                        res_idx_next = mode_next;
                        res_val_next = hi_cnt_next;
                        res_in_next  = 1'b1;
                        state_next   = whe_pkg::ST_LIK_DIV;
                    end else begin
                        state_next = whe_pkg::ST_SPR_HI;
                    end
                end else begin
                    mem_raddr   = AW'(sw_idx_reg + IW'(1));
                    sw_idx_next = sw_idx_reg + IW'(1);
                end
                if (sw_first) begin
                    mem_raddr = AW'(IW'(1));
                end
            end
            whe_pkg::ST_LIK_DIV: begin
                if (div_res.done) begin
                    res_lik_next = div_lik;
                    div_start    = 1'b1;
                    div_num      = DW'({ctr_mag, 15'b0});
                    div_den      = DW'(b_eff);
                    ctr_neg_next = ctr_neg;
                    state_next   = whe_pkg::ST_CTR_DIV;
                end
            end
            whe_pkg::ST_CTR_DIV: begin
                if (div_res.done) begin
                    res_ctr_next = ctr_val;
                    state_next   = whe_pkg::ST_DONE;
                end
            end
            whe_pkg::ST_SPR_HI: begin
                lik_cnt = lo_cnt_reg;
                if (div_res.done) begin
                    res_lik_next = div_lik;
                    div_start    = 1'b1;
                    state_next   = whe_pkg::ST_SPR_LO;
                end
            end
            whe_pkg::ST_SPR_LO: begin
                if (div_res.done) begin
                    res_lik_next = res_lik_reg - div_lik;
                    state_next   = whe_pkg::ST_DONE;
                end
            end
            whe_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_ctr_reg, res_lik_reg, total_reg, res_val_reg,
                                     res_idx_reg[7:0]};
                    m_tuser_next  = res_in_reg;
                    state_next    = whe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = whe_pkg::ST_IDLE;
            end
        endcase
    end

    // the sweep's first read is issued as the request is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= whe_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_rpt_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            total_reg    <= '0;
            min_reg      <= 16'sd0;
            max_reg      <= 16'sd256;
            bins_reg     <= IW'(256);
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_rpt_reg  <= clr_rpt_next;
            m_tvalid_reg <= m_tvalid_next;
            total_reg    <= total_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    whe_pkg::CFG_RANGE_MIN: min_reg  <= cfg_data;
                    whe_pkg::CFG_RANGE_MAX: max_reg  <= cfg_data;
                    whe_pkg::CFG_BINS:      bins_reg <= cfg_data[IW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        weight_reg  <= weight_next;
        sw_idx_reg  <= sw_idx_next;
        mode_reg    <= mode_next;
        hi_cnt_reg  <= hi_cnt_next;
        lo_cnt_reg  <= lo_cnt_next;
        ctr_neg_reg <= ctr_neg_next;
        res_idx_reg <= res_idx_next;
        res_in_reg  <= res_in_next;
        res_val_reg <= res_val_next;
        res_lik_reg <= res_lik_next;
        res_ctr_reg <= res_ctr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    whe_bin_ram #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    whe_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // a new division never overruns one in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_res.busy)
        else $error("divider restarted while busy");

    // the store is only written by an add or a clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == whe_pkg::ST_ADD_WR || state_reg == whe_pkg::ST_CLEAR))
        else $error("unexpected store write");

    // a reported bin always lies inside the bins in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> ({1'b0, m_tdata[7:0]} < b_eff))
        else $error("reported bin outside the bins in use");

    // a finished result reaches the output register on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == whe_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("finished result not presented");

endmodule
